// ===== src/c_subset_lexer_top_defines.svh =====
// assertion macros for the lexer checker
`ifndef C_SUBSET_LEXER_TOP_DEFINES_SVH
`define C_SUBSET_LEXER_TOP_DEFINES_SVH
// implication under reset
`define CSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");
// next-cycle implication under reset
`define CSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");
`endif

// ===== src/csl_pkg.sv =====
`default_nettype none
package csl_pkg;
  localparam int NameChars = 8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] number_value;
    logic [63:0] ident_text;
    logic [7:0]  ident_length;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_DEC, M_ZERO, M_HEX0, M_HEX, M_BIN0, M_BIN, M_OCT,
    M_CHOPEN, M_CHESC, M_CHCLOSE, M_PLUS, M_MINUS, M_SLASH, M_GT, M_LT,
    M_EQ, M_AMP, M_BAR, M_BANG, M_LINE, M_BLOCK
  } mode_t;

  localparam logic [5:0] T_END = 6'd0, T_IDENT = 6'd1, T_NUM = 6'd2,
    T_KW0 = 6'd3, T_PLUS = 6'd11, T_INC = 6'd12, T_MINUS = 6'd13,
    T_DEC = 6'd14, T_STAR = 6'd15, T_SLASH = 6'd16, T_PCT = 6'd17,
    T_GT = 6'd18, T_GE = 6'd19, T_LT = 6'd20, T_LE = 6'd21, T_ASSIGN = 6'd22,
    T_EQ = 6'd23, T_NOT = 6'd24, T_NE = 6'd25, T_AMP = 6'd26, T_AND = 6'd27,
    T_OR = 6'd28, T_COMMA = 6'd29, T_COLON = 6'd30, T_SEMI = 6'd31,
    T_LPAR = 6'd32, T_RPAR = 6'd33, T_LBRK = 6'd34, T_RBRK = 6'd35,
    T_LBRC = 6'd36, T_RBRC = 6'd37;

  // one token emission, before the run flag is set
  typedef struct packed {
    logic        vld;
    logic [5:0]  kind;
    logic [31:0] num;
    logic [63:0] text;
    logic [7:0]  len;
  } tok_t;

  // what one step produces for the output stage
  typedef struct packed {
    tok_t t0;
    tok_t t1;
  } step_res_t;

  // keyword text packed first char in low byte, with length
  function automatic logic [63:0] kw_text(input logic [2:0] k);
    case (k)
      3'd0: kw_text = 64'h746e69;
      3'd1: kw_text = 64'h64696f76;
      3'd2: kw_text = 64'h6669;
      3'd3: kw_text = 64'h65736c65;
      3'd4: kw_text = 64'h656c696877;
      3'd5: kw_text = 64'h6b61657262;
      3'd6: kw_text = 64'h65756e69746e6f63;
      3'd7: kw_text = 64'h6e72757465720000 >> 16;
      default: kw_text = '0;
    endcase
  endfunction

  function automatic logic [7:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0: kw_len = 8'd3;
      3'd1: kw_len = 8'd4;
      3'd2: kw_len = 8'd2;
      3'd3: kw_len = 8'd4;
      3'd4: kw_len = 8'd5;
      3'd5: kw_len = 8'd5;
      3'd6: kw_len = 8'd8;
      3'd7: kw_len = 8'd6;
      default: kw_len = 8'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== src/c_subset_lexer_top.sv =====
`default_nettype none
// C subset lexer: one source byte per input item, tokens out. An item is
// taken in every cycle while the result buffer is empty or its last token
// is being taken in that same cycle, so plain text streams at one byte per
// cycle; a byte that completes two tokens holds input while the second
// token drains from the two-entry result buffer.
module c_subset_lexer_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  csl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output csl_pkg::out_item_t  out_data
);
  import csl_pkg::*;

  step_res_t res;
  logic busy, adv;

  assign in_ready = !busy;
  assign adv = in_valid && in_ready;

  // per-byte lexer step
  csl_step u_step (.clk(clk), .rst_n(rst_n), .adv(adv), .item(in_data), .res(res));

  // result buffer
  csl_out u_out (.clk(clk), .rst_n(rst_n), .load(adv), .res(res), .busy(busy),
                 .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
endmodule
`default_nettype wire

// ===== src/csl_step.sv =====
`default_nettype none
module csl_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  csl_pkg::in_item_t         item,
  output csl_pkg::step_res_t        res
);
  import csl_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [63:0] name_r, name_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        star_r, star_nxt;

  logic [7:0] c;
  logic is_al, is_dg, is_oc, is_hx;
  logic [3:0] hv;
  tok_t id_tok, num_tok;
  // start() outcome
  mode_t st_mode;
  tok_t  st_tok;
  logic [31:0] st_acc;
  logic [63:0] st_name;
  logic [7:0]  st_cnt;

  assign c = item.char_code;
  assign is_al = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  assign is_dg = c >= 8'h30 && c <= 8'h39;
  assign is_oc = c >= 8'h30 && c <= 8'h37;
  assign is_hx = is_dg || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  assign hv = is_dg ? c[3:0] : 4'(c[3:0] + 4'd9);

  function automatic tok_t op(input logic [5:0] k);
    op = '{vld: 1'b1, kind: k, num: '0, text: '0, len: '0};
  endfunction

  // identifier or keyword token from the buffer
  always_comb begin
    id_tok = '{vld: 1'b1, kind: T_IDENT, num: '0, text: name_r, len: cnt_r};
    for (int k = 0; k < 8; k++) begin
      if (cnt_r == kw_len(3'(k)) && name_r == kw_text(3'(k))) begin
        id_tok = op(6'(T_KW0 + 6'(k)));
      end
    end
  end
  assign num_tok = '{vld: 1'b1, kind: T_NUM, num: acc_r, text: '0, len: '0};

  // scanning afresh from idle
  always_comb begin
    st_mode = M_IDLE;
    st_tok  = '0;
    st_acc  = acc_r;
    st_name = name_r;
    st_cnt  = cnt_r;
    if (is_al) begin
      st_mode = M_IDENT;
      st_name = {56'd0, c};
      st_cnt  = 8'd1;
    end else if (is_dg) begin
      st_acc  = {28'd0, c[3:0]};
      st_mode = (c == 8'h30) ? M_ZERO : M_DEC;
    end else begin
      case (c)
        8'h27: st_mode = M_CHOPEN;
        8'h23: st_mode = M_LINE;
        8'h2b: st_mode = M_PLUS;
        8'h2d: st_mode = M_MINUS;
        8'h2f: st_mode = M_SLASH;
        8'h3e: st_mode = M_GT;
        8'h3c: st_mode = M_LT;
        8'h3d: st_mode = M_EQ;
        8'h26: st_mode = M_AMP;
        8'h7c: st_mode = M_BAR;
        8'h21: st_mode = M_BANG;
        8'h2a: st_tok = op(T_STAR);
        8'h25: st_tok = op(T_PCT);
        8'h2c: st_tok = op(T_COMMA);
        8'h3a: st_tok = op(T_COLON);
        8'h3b: st_tok = op(T_SEMI);
        8'h28: st_tok = op(T_LPAR);
        8'h29: st_tok = op(T_RPAR);
        8'h5b: st_tok = op(T_LBRK);
        8'h5d: st_tok = op(T_RBRK);
        8'h7b: st_tok = op(T_LBRC);
        8'h7d: st_tok = op(T_RBRC);
        default: st_mode = M_IDLE;
      endcase
    end
  end

  // per-item transition
  always_comb begin
    logic restart;
    logic [5:0] pk, sk;
    logic [7:0] pc;
    tok_t pre;
    restart = 1'b0;
    pre = '0;
    pk = T_END;
    sk = T_END;
    pc = 8'h00;
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    name_nxt = name_r;
    cnt_nxt = cnt_r;
    star_nxt = star_r;
    res = '0;
    if (item.end_of_input) begin
      case (mode_r)
        M_IDENT: pre = id_tok;
        M_DEC, M_ZERO, M_HEX, M_BIN, M_OCT: pre = num_tok;
        M_PLUS: pre = op(T_PLUS);
        M_MINUS: pre = op(T_MINUS);
        M_SLASH: pre = op(T_SLASH);
        M_GT: pre = op(T_GT);
        M_LT: pre = op(T_LT);
        M_EQ: pre = op(T_ASSIGN);
        M_AMP: pre = op(T_AMP);
        M_BANG: pre = op(T_NOT);
        default: pre = '0;
      endcase
      res.t0 = pre;
      res.t1 = op(T_END);
      mode_nxt = M_IDLE;
      acc_nxt = '0;
      name_nxt = '0;
      cnt_nxt = '0;
      star_nxt = 1'b0;
    end else begin
      // two-character operator table
      case (mode_r)
        M_PLUS:  begin pc = 8'h2b; pk = T_INC; sk = T_PLUS;   end
        M_MINUS: begin pc = 8'h2d; pk = T_DEC; sk = T_MINUS;  end
        M_GT:    begin pc = 8'h3d; pk = T_GE;  sk = T_GT;     end
        M_LT:    begin pc = 8'h3d; pk = T_LE;  sk = T_LT;     end
        M_EQ:    begin pc = 8'h3d; pk = T_EQ;  sk = T_ASSIGN; end
        M_AMP:   begin pc = 8'h26; pk = T_AND; sk = T_AMP;    end
        M_BAR:   begin pc = 8'h7c; pk = T_OR;  sk = T_END;    end
        M_BANG:  begin pc = 8'h3d; pk = T_NE;  sk = T_NOT;    end
        default: begin pc = 8'h00; pk = T_END; sk = T_END;    end
      endcase
      case (mode_r)
        M_IDENT: begin
          if (is_al || is_dg) begin
            if (cnt_r < 8'(NameChars)) name_nxt = name_r | ({56'd0, c} << {cnt_r[2:0], 3'b000});
            if (cnt_r != 8'hff) cnt_nxt = 8'(cnt_r + 8'd1);
          end else begin
            pre = id_tok;
            restart = 1'b1;
          end
        end
        M_DEC: begin
          if (is_dg) acc_nxt = 32'((acc_r << 3) + (acc_r << 1) + {28'd0, c[3:0]});
          else begin pre = num_tok; restart = 1'b1; end
        end
        M_ZERO: begin
          if (c == 8'h78) mode_nxt = M_HEX0;
          else if (c == 8'h62) mode_nxt = M_BIN0;
          else if (is_oc) begin acc_nxt = {29'd0, c[2:0]}; mode_nxt = M_OCT; end
          else begin pre = num_tok; restart = 1'b1; end
        end
        M_HEX0, M_HEX: begin
          if (is_hx) begin
            acc_nxt = (mode_r == M_HEX0) ? {28'd0, hv} : {acc_r[27:0], hv};
            mode_nxt = M_HEX;
          end else begin
            if (mode_r == M_HEX) pre = num_tok;
            restart = 1'b1;
          end
        end
        M_BIN0, M_BIN: begin
          if (c == 8'h30 || c == 8'h31) begin
            acc_nxt = (mode_r == M_BIN0) ? {31'd0, c[0]} : {acc_r[30:0], c[0]};
            mode_nxt = M_BIN;
          end else begin
            if (mode_r == M_BIN) pre = num_tok;
            restart = 1'b1;
          end
        end
        M_OCT: begin
          if (is_oc) acc_nxt = {acc_r[28:0], c[2:0]};
          else begin pre = num_tok; restart = 1'b1; end
        end
        M_CHOPEN: begin
          if (c == 8'h5c) mode_nxt = M_CHESC;
          else if (c == 8'h0a) restart = 1'b1;
          else if (c == 8'h27) mode_nxt = M_IDLE;
          else mode_nxt = M_CHCLOSE;
        end
        M_CHESC: begin
          if (c == 8'h0a) restart = 1'b1;
          else mode_nxt = M_CHCLOSE;
        end
        M_CHCLOSE: begin
          if (c == 8'h27) mode_nxt = M_IDLE;
          else restart = 1'b1;
        end
        M_PLUS, M_MINUS, M_GT, M_LT, M_EQ, M_AMP, M_BAR, M_BANG: begin
          if (c == pc) begin
            pre = op(pk);
            mode_nxt = M_IDLE;
          end else begin
            if (mode_r != M_BAR) pre = op(sk);
            restart = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == 8'h2f) mode_nxt = M_LINE;
          else if (c == 8'h2a) begin mode_nxt = M_BLOCK; star_nxt = 1'b0; end
          else begin pre = op(T_SLASH); restart = 1'b1; end
        end
        M_LINE: begin
          if (c == 8'h0a) mode_nxt = M_IDLE;
        end
        M_BLOCK: begin
          if (c == 8'h2f && star_r) begin mode_nxt = M_IDLE; star_nxt = 1'b0; end
          else star_nxt = (c == 8'h2a);
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        mode_nxt = st_mode;
        acc_nxt = st_acc;
        name_nxt = st_name;
        cnt_nxt = st_cnt;
      end
      res.t0 = pre;
      res.t1 = restart ? st_tok : tok_t'('0);
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r <= '0;
      name_r <= '0;
      cnt_r <= '0;
      star_r <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      acc_r <= acc_nxt;
      name_r <= name_nxt;
      cnt_r <= cnt_nxt;
      star_r <= star_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/csl_out.sv =====
`default_nettype none
module csl_out (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  csl_pkg::step_res_t        res,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output csl_pkg::out_item_t        out_data
);
  import csl_pkg::*;

  // two-entry result buffer: head in slot a, second in slot b
  tok_t a_r, b_r;
  logic a_vld_r, b_vld_r;
  tok_t f0, f1;
  logic pop;

  // compact so the first valid token sits in f0
  always_comb begin
    if (res.t0.vld) begin
      f0 = res.t0;
      f1 = res.t1;
    end else begin
      f0 = res.t1;
      f1 = '0;
    end
  end

  assign pop = out_valid && out_ready;
  assign out_valid = a_vld_r;
  assign busy = a_vld_r && !(pop && !b_vld_r);
  assign out_data = '{token_kind: a_r.kind, number_value: a_r.num,
                      ident_text: a_r.text, ident_length: a_r.len,
                      last_of_run: !b_vld_r};

  // shift on pop, fill on load (load only when empty after pop)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (load) begin
      a_vld_r <= f0.vld;
      b_vld_r <= f1.vld;
      a_r <= f0;
      b_r <= f1;
    end else if (pop) begin
      a_vld_r <= b_vld_r;
      b_vld_r <= 1'b0;
      a_r <= b_r;
    end
  end
endmodule
`default_nettype wire

// ===== src/csl_checker.sv =====
`default_nettype none
`include "c_subset_lexer_top_defines.svh"
module csl_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input csl_pkg::in_item_t      in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input csl_pkg::out_item_t     out_data
);
  import csl_pkg::*;

  // a stalled result holds
  `CSL_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // end marker always ends with END as the run's last token
  `CSL_ASSERT_IMP(a_end_last, out_valid && out_data.token_kind == T_END, out_data.last_of_run)
  // numbers carry no text (zero identifier length)
  `CSL_ASSERT_IMP(a_num_clean, out_valid && out_data.token_kind == T_NUM, out_data.ident_length == 8'd0)
  // a held first token blocks input
  `CSL_ASSERT_IMP(a_block, out_valid && !out_data.last_of_run, !in_ready)
endmodule

bind c_subset_lexer_top csl_checker u_chk (.*);
`default_nettype wire
